@@ hdl/qform_pkg.sv @@
// Shared types, constants and step functions of the qform-to-affine core.
// Used by qform_quaternion_to_affine_core; depends on nothing else.
package qform_pkg;

    localparam int QBITS      = 30;
    localparam int W_MIN      = 107;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;

    // Pipeline stage numbers.
    localparam int ST_IN     = 0;
    localparam int ST_SQ     = 1;
    localparam int ST_SUM    = 2;
    localparam int ST_SQ_END = ST_SUM + SQRT_STEPS;
    localparam int ST_DG     = ST_SQ_END + 1;
    localparam int ST_DV_END = ST_DG + DIV_STEPS;
    localparam int ST_SEL    = ST_DV_END + 1;
    localparam int ST_PRD    = ST_SEL + 1;
    localparam int ST_ROT    = ST_PRD + 1;
    localparam int ST_Q30    = ST_ROT + 1;
    localparam int ST_MUL    = ST_Q30 + 1;
    localparam int ST_COL    = ST_MUL + 1;

    localparam int IN_W   = 312;
    localparam int OUT_W  = 128;
    localparam int USER_W = 3;

    typedef struct packed {
        logic             err;
        logic [2:0][31:0] off;
        logic [2:0][32:0] sc;
    } side_t;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } sq_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [30:0] low;
        logic [30:0] q;
    } dv_t;

    // One digit of the bit-pair integer square root; k counts from the top pair.
    function automatic sq_t sqrt_step(input sq_t s, input int k);
        logic [63:0] bitv;
        sq_t         o;
        bitv = 64'd1 << (62 - 2 * k);
        if (s.v >= s.r + bitv)
        begin
            o.v = s.v - (s.r + bitv);
            o.r = (s.r >> 1) + bitv;
        end
        else
        begin
            o.v = s.v;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    // One quotient bit of a restoring division.
    function automatic dv_t div_step(input dv_t s, input logic [31:0] d);
        logic [32:0] t;
        logic        ge;
        dv_t         o;
        t  = {s.rem, s.low[30]};
        ge = (t >= {1'b0, d});
        o.rem = ge ? 32'(t - {1'b0, d}) : t[31:0];
        o.low = {s.low[29:0], 1'b0};
        o.q   = {s.q[29:0], ge};
        return o;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sh007FFFFFFF)
            return 32'h7FFFFFFF;
        else if (v < -40'sh0080000000)
            return 32'h80000000;
        else
            return v[31:0];
    endfunction

endpackage

@@ hdl/qform_quaternion_to_affine_core.sv @@
// Throughput: one input transaction per cycle into the pipeline while s_tready is high;
// the whole pipeline stalls while the output buffer holds an item whose last row is not
// taken. Each item leaves as three results (one on error), so the output port sets the
// sustained rate. The sqrt digit chain (32 stages) and the dividers (31 stages) set depth.
// Reset: rst_n clears all valid bits and the output buffer; no other state is kept.
// Depends on qform_pkg.
module qform_quaternion_to_affine_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // hdr_code[15:0], quat_b, quat_c, quat_d, offset_x, offset_y, offset_z,
    // voxel_size_i, voxel_size_j, voxel_size_k, qfac_negative, dim_count[2:0], zero pad
    input  logic [qform_pkg::IN_W-1:0]   s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // entry_0, entry_1, entry_2, entry_3 (32 bits each)
    output logic [qform_pkg::OUT_W-1:0]  m_tdata,
    // row_index[1:0], error
    output logic [qform_pkg::USER_W-1:0] m_tuser,
    output logic                         m_tlast
);

    localparam logic [32:0] ONE = 33'd1 << FRAC_BITS;
    localparam logic [63:0] UNIT60 = 64'd1 << 60;

    logic en;

    logic              vld_reg  [0:qform_pkg::ST_COL];
    qform_pkg::side_t  side_reg [0:qform_pkg::ST_COL];
    logic [2:0][31:0]  xyz_reg  [0:qform_pkg::ST_DV_END];
    logic [2:0][63:0]  sq_reg;
    qform_pkg::sq_t    sa_reg   [qform_pkg::ST_SUM:qform_pkg::ST_SQ_END];
    qform_pkg::sq_t    sb_reg   [qform_pkg::ST_SUM:qform_pkg::ST_SQ_END];
    logic              deg0_reg [qform_pkg::ST_SUM:qform_pkg::ST_SQ_END];
    logic              dg_reg   [qform_pkg::ST_DG:qform_pkg::ST_DV_END];
    logic [31:0]       nn_reg   [qform_pkg::ST_DG:qform_pkg::ST_DV_END];
    logic [30:0]       w_reg    [qform_pkg::ST_DG:qform_pkg::ST_DV_END];
    qform_pkg::dv_t    dv_reg   [qform_pkg::ST_DG:qform_pkg::ST_DV_END][0:2];
    logic [3:0][31:0]  sel_reg;
    logic [9:0][63:0]  pr_reg;
    logic [8:0][63:0]  rot_reg;
    logic [8:0][34:0]  q30_reg;
    logic [8:0][67:0]  mul_reg;
    logic [8:0][37:0]  col_reg;

    logic [3:0][31:0]  row_reg [0:2];
    logic              berr_reg;
    logic              bval_reg;
    logic [1:0]        row_cnt_reg;

    qform_pkg::side_t  side_next;
    logic [2:0][63:0]  sq_next;
    logic [63:0]       sum_next;
    logic              deg0_next;
    logic [30:0]       w_next;
    logic              dg_next;
    qform_pkg::dv_t    dv0_next [0:2];
    logic [3:0][31:0]  sel_next;
    logic [9:0][63:0]  pr_next;
    logic [8:0][63:0]  rot_next;
    logic [8:0][34:0]  q30_next;
    logic [8:0][67:0]  mul_next;
    logic [8:0][37:0]  col_next;
    logic [3:0][31:0]  row_next [0:2];

    assign en       = !bval_reg || (m_tready && m_tlast);
    assign s_tready = en;

    // Input decode: error flag, offsets and the chosen scales.
    always_comb
    begin
        logic [2:0]         n;
        logic signed [31:0] v;
        n = (s_tdata[307:305] > 3'd3) ? 3'd3 : s_tdata[307:305];
        side_next.err = s_tdata[15] || (s_tdata[15:0] == 16'd0);
        for (int i = 0; i < 3; i++)
        begin
            side_next.off[i] = s_tdata[112 + 32 * i +: 32];
            v = s_tdata[208 + 32 * i +: 32];
            if (3'(i) < n)
                side_next.sc[i] = (v < 0) ? ONE : {v[31], v};
            else
                side_next.sc[i] = ONE;
        end
        if (s_tdata[304])
            side_next.sc[2] = 33'(-$signed(side_next.sc[2]));
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sq_next[i] = 64'($signed(xyz_reg[qform_pkg::ST_IN][i]))
                       * 64'($signed(xyz_reg[qform_pkg::ST_IN][i]));
        sum_next  = sq_reg[0] + sq_reg[1] + sq_reg[2];
        deg0_next = sum_next > UNIT60;
    end

    // Degenerate test and divider setup for normalizing b, c, d.
    always_comb
    begin
        logic [31:0] mag;
        logic [61:0] dvd;
        w_next  = sa_reg[qform_pkg::ST_SQ_END].r[30:0];
        dg_next = deg0_reg[qform_pkg::ST_SQ_END] || (w_next < 31'(qform_pkg::W_MIN));
        for (int c = 0; c < 3; c++)
        begin
            mag = xyz_reg[qform_pkg::ST_SQ_END][c][31]
                ? 32'(-xyz_reg[qform_pkg::ST_SQ_END][c])
                : xyz_reg[qform_pkg::ST_SQ_END][c];
            dvd = {mag, 30'd0};
            dv0_next[c].rem = {1'b0, dvd[61:31]};
            dv0_next[c].low = dvd[30:0];
            dv0_next[c].q   = '0;
        end
    end

    always_comb
    begin
        logic [31:0] qv;
        for (int c = 0; c < 3; c++)
        begin
            qv = {1'b0, dv_reg[qform_pkg::ST_DV_END][c].q};
            if (!dg_reg[qform_pkg::ST_DV_END])
                sel_next[c] = xyz_reg[qform_pkg::ST_DV_END][c];
            else if (nn_reg[qform_pkg::ST_DV_END] == 32'd0)
                sel_next[c] = '0;
            else
                sel_next[c] = xyz_reg[qform_pkg::ST_DV_END][c][31] ? 32'(-qv) : qv;
        end
        sel_next[3] = dg_reg[qform_pkg::ST_DV_END] ? 32'd0
                                                    : {1'b0, w_reg[qform_pkg::ST_DV_END]};
    end

    // Order of products: xx, yy, zz, ww, xy, xz, xw, yz, yw, zw.
    always_comb
    begin
        logic signed [63:0] s [0:3];
        for (int c = 0; c < 4; c++)
            s[c] = 64'($signed(sel_reg[c]));
        pr_next[0] = s[0] * s[0];
        pr_next[1] = s[1] * s[1];
        pr_next[2] = s[2] * s[2];
        pr_next[3] = s[3] * s[3];
        pr_next[4] = s[0] * s[1];
        pr_next[5] = s[0] * s[2];
        pr_next[6] = s[0] * s[3];
        pr_next[7] = s[1] * s[2];
        pr_next[8] = s[1] * s[3];
        pr_next[9] = s[2] * s[3];
    end

    always_comb
    begin
        logic signed [63:0] xx, yy, zz, ww, xy, xz, xw, yz, yw, zw;
        xx = pr_reg[0]; yy = pr_reg[1]; zz = pr_reg[2]; ww = pr_reg[3];
        xy = pr_reg[4]; xz = pr_reg[5]; xw = pr_reg[6];
        yz = pr_reg[7]; yw = pr_reg[8]; zw = pr_reg[9];
        rot_next[0] = xx - yy - zz + ww;
        rot_next[1] = (xy - zw) <<< 1;
        rot_next[2] = (xz + yw) <<< 1;
        rot_next[3] = (xy + zw) <<< 1;
        rot_next[4] = yy - xx - zz + ww;
        rot_next[5] = (yz - xw) <<< 1;
        rot_next[6] = (xz - yw) <<< 1;
        rot_next[7] = (yz + xw) <<< 1;
        rot_next[8] = zz - xx - yy + ww;
    end

    // Round half up to Q30, scale, then round half up to the output format.
    always_comb
    begin
        logic signed [63:0] t64;
        logic signed [67:0] p68;
        logic signed [67:0] t68;
        for (int i = 0; i < 9; i++)
        begin
            t64 = $signed(rot_reg[i]) + (64'sd1 <<< (qform_pkg::QBITS - 1));
            q30_next[i] = 35'(t64 >>> qform_pkg::QBITS);
            p68 = 68'($signed(q30_reg[i]))
                * 68'($signed(side_reg[qform_pkg::ST_Q30].sc[i % 3]));
            mul_next[i] = p68;
            t68 = $signed(mul_reg[i]) + (68'sd1 <<< (qform_pkg::QBITS - 1));
            col_next[i] = 38'(t68 >>> qform_pkg::QBITS);
        end
    end

    always_comb
    begin
        logic signed [39:0] t;
        for (int r = 0; r < 3; r++)
        begin
            t = 40'($signed(side_reg[qform_pkg::ST_COL].off[r]));
            for (int i = 0; i < 3; i++)
            begin
                t = t - 40'($signed(col_reg[3 * r + i]));
                row_next[r][i] = qform_pkg::sat32(40'($signed(col_reg[3 * r + i])));
            end
            row_next[r][3] = qform_pkg::sat32(t);
            if (side_reg[qform_pkg::ST_COL].err)
                row_next[r] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= qform_pkg::ST_COL; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k <= qform_pkg::ST_COL; k++)
                vld_reg[k] <= vld_reg[k - 1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k <= qform_pkg::ST_COL; k++)
                side_reg[k] <= side_reg[k - 1];
            xyz_reg[0] <= s_tdata[111:16];
            for (int k = 1; k <= qform_pkg::ST_DV_END; k++)
                xyz_reg[k] <= xyz_reg[k - 1];
            sq_reg <= sq_next;
            sa_reg[qform_pkg::ST_SUM]   <= '{v: deg0_next ? 64'd0 : UNIT60 - sum_next,
                                             r: 64'd0};
            sb_reg[qform_pkg::ST_SUM]   <= '{v: sum_next, r: 64'd0};
            deg0_reg[qform_pkg::ST_SUM] <= deg0_next;
            for (int k = qform_pkg::ST_SUM + 1; k <= qform_pkg::ST_SQ_END; k++)
                deg0_reg[k] <= deg0_reg[k - 1];
            dg_reg[qform_pkg::ST_DG] <= dg_next;
            nn_reg[qform_pkg::ST_DG] <= sb_reg[qform_pkg::ST_SQ_END].r[31:0];
            w_reg[qform_pkg::ST_DG]  <= w_next;
            for (int c = 0; c < 3; c++)
                dv_reg[qform_pkg::ST_DG][c] <= dv0_next[c];
            for (int k = qform_pkg::ST_DG + 1; k <= qform_pkg::ST_DV_END; k++)
            begin
                dg_reg[k] <= dg_reg[k - 1];
                nn_reg[k] <= nn_reg[k - 1];
                w_reg[k]  <= w_reg[k - 1];
            end
            sel_reg <= sel_next;
            pr_reg  <= pr_next;
            rot_reg <= rot_next;
            q30_reg <= q30_next;
            mul_reg <= mul_next;
            col_reg <= col_next;
        end
    end

    // Square-root digit stages: one for the w radicand, one for the norm.
    for (genvar k = 1; k <= qform_pkg::SQRT_STEPS; k++)
    begin : g_sqrt
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sa_reg[qform_pkg::ST_SUM + k] <=
                    qform_pkg::sqrt_step(sa_reg[qform_pkg::ST_SUM + k - 1], k - 1);
                sb_reg[qform_pkg::ST_SUM + k] <=
                    qform_pkg::sqrt_step(sb_reg[qform_pkg::ST_SUM + k - 1], k - 1);
            end
        end
    end

    for (genvar j = 1; j <= qform_pkg::DIV_STEPS; j++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int c = 0; c < 3; c++)
                    dv_reg[qform_pkg::ST_DG + j][c] <=
                        qform_pkg::div_step(dv_reg[qform_pkg::ST_DG + j - 1][c],
                                            nn_reg[qform_pkg::ST_DG + j - 1]);
            end
        end
    end

    // Output buffer: holds one item and hands out its rows one transaction at a time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bval_reg    <= 1'b0;
            row_cnt_reg <= 2'd0;
        end
        else if (en)
        begin
            bval_reg    <= vld_reg[qform_pkg::ST_COL];
            row_cnt_reg <= 2'd0;
        end
        else if (m_tready)
        begin
            row_cnt_reg <= row_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            berr_reg <= side_reg[qform_pkg::ST_COL].err;
            for (int r = 0; r < 3; r++)
                row_reg[r] <= row_next[r];
        end
    end

    assign m_tvalid = bval_reg;
    assign m_tdata  = row_reg[row_cnt_reg];
    assign m_tuser  = {berr_reg, row_cnt_reg};
    assign m_tlast  = berr_reg || (row_cnt_reg == 2'd2);

endmodule

@@ tb/qform_affine_checker.sv @@
// Checker for the qform-to-affine core: watches both stream channels, predicts the affine rows
// of every accepted header transaction and compares them with the results. Depends on qform_pkg.
module qform_affine_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [qform_pkg::IN_W-1:0]   s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [qform_pkg::OUT_W-1:0]  m_tdata,
    input  logic [qform_pkg::USER_W-1:0] m_tuser,
    input  logic                         m_tlast,
    output int                           errors,
    output int                           pending
);
    localparam int FB = 16;

    typedef struct packed {
        logic [1:0]  row;
        logic [31:0] e0;
        logic [31:0] e1;
        logic [31:0] e2;
        logic [31:0] e3;
        logic        err;
        logic        last;
    } affine_row_t;

    affine_row_t rows_due[$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint floor_sh(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint round_sh(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic longint unit_comp(input longint q, input longint n);
        longint mag;
        longint r;
        mag = (q < 0) ? -q : q;
        r = (mag * (64'sd1 <<< 30)) / n;
        return (q < 0) ? -r : r;
    endfunction

    task automatic predict_affine(input logic [qform_pkg::IN_W-1:0] d);
        longint      code;
        longint      x;
        longint      y;
        longint      z;
        longint      w;
        longint      nn;
        longint      one;
        longint      v;
        longint      t;
        longint      q30;
        longint      off[3];
        longint      sc[3];
        longint      rot[3][3];
        longint      col[3];
        logic [63:0] sumsq;
        logic [63:0] lim;
        int          n;
        bit          degen;
        affine_row_t a;
        code = longint'($signed(d[15:0]));
        x = longint'($signed(d[47:16]));
        y = longint'($signed(d[79:48]));
        z = longint'($signed(d[111:80]));
        one = 64'sd1 <<< FB;
        if (code <= 0)
        begin
            a = '0;
            a.err = 1'b1;
            a.last = 1'b1;
            rows_due.push_back(a);
            return;
        end
        n = int'(d[307:305]);
        if (n > 3)
            n = 3;
        for (int i = 0; i < 3; i++)
        begin
            off[i] = longint'($signed(d[112 + 32 * i +: 32]));
            v = longint'($signed(d[208 + 32 * i +: 32]));
            sc[i] = (i < n) ? ((v < 0) ? one : v) : one;
        end
        if (d[304])
            sc[2] = -sc[2];
        sumsq = x * x + y * y + z * z;
        lim = 64'd1 << 60;
        w = 0;
        degen = sumsq > lim;
        if (!degen)
        begin
            w = longint'(int_sqrt(lim - sumsq));
            degen = w < 107;
        end
        if (degen)
        begin
            nn = longint'(int_sqrt(sumsq));
            if (nn == 0)
            begin
                x = 0;
                y = 0;
                z = 0;
            end
            else
            begin
                x = unit_comp(x, nn);
                y = unit_comp(y, nn);
                z = unit_comp(z, nn);
            end
            w = 0;
        end
        rot[0][0] = x * x - y * y - z * z + w * w;
        rot[0][1] = 2 * (x * y - z * w);
        rot[0][2] = 2 * (x * z + y * w);
        rot[1][0] = 2 * (x * y + z * w);
        rot[1][1] = -x * x + y * y - z * z + w * w;
        rot[1][2] = 2 * (y * z - x * w);
        rot[2][0] = 2 * (x * z - y * w);
        rot[2][1] = 2 * (y * z + x * w);
        rot[2][2] = -x * x - y * y + z * z + w * w;
        for (int r = 0; r < 3; r++)
        begin
            t = off[r];
            for (int i = 0; i < 3; i++)
            begin
                q30 = round_sh(rot[r][i], 30);
                col[i] = round_sh(q30 * sc[i], 30);
                t = t - col[i];
            end
            a.row = r[1:0];
            a.e0 = clamp32(col[0]);
            a.e1 = clamp32(col[1]);
            a.e2 = clamp32(col[2]);
            a.e3 = clamp32(t);
            a.err = 1'b0;
            a.last = (r == 2);
            rows_due.push_back(a);
        end
    endtask

    always @(posedge clk)
    begin
        affine_row_t got;
        affine_row_t exp_row;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_affine(s_tdata);
            if (m_tvalid && m_tready)
            begin
                got.row = m_tuser[1:0];
                got.err = m_tuser[2];
                got.e0 = m_tdata[31:0];
                got.e1 = m_tdata[63:32];
                got.e2 = m_tdata[95:64];
                got.e3 = m_tdata[127:96];
                got.last = m_tlast;
                if (rows_due.size() == 0)
                begin
                    $display("%0t: result with nothing expected: %h", $time, got);
                    errors++;
                end
                else
                begin
                    exp_row = rows_due.pop_front();
                    if (got !== exp_row)
                    begin
                        $display("%0t: mismatch expected row=%0d e=%h %h %h %h err=%b last=%b",
                                 $time, exp_row.row, exp_row.e0, exp_row.e1, exp_row.e2,
                                 exp_row.e3, exp_row.err, exp_row.last);
                        $display("%0t:            actual row=%0d e=%h %h %h %h err=%b last=%b",
                                 $time, got.row, got.e0, got.e1, got.e2, got.e3, got.err,
                                 got.last);
                        errors++;
                    end
                end
            end
        end
        pending = rows_due.size();
    end
endmodule

@@ tb/tb_qform_quaternion_to_affine_core.sv @@
// Testbench top for qform_quaternion_to_affine_core: drives header transactions under
// several idle and stall phases and reports the verdict. Depends on qform_pkg and the checker.
module tb_qform_quaternion_to_affine_core;
    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [qform_pkg::IN_W-1:0]   s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [qform_pkg::OUT_W-1:0]  m_tdata;
    logic [qform_pkg::USER_W-1:0] m_tuser;
    logic                         m_tlast;
    int                           errors;
    int                           pending;
    int                           send_idle_pct;
    int                           stall_pct;

    qform_quaternion_to_affine_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    qform_affine_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .errors(errors), .pending(pending)
    );

    initial
        clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [31:0] rand_quat();
        case ($urandom_range(5))
            0: return 32'h40000000;
            1: return 32'hC0000000;
            2: return 32'(int'($urandom_range(2147483647)) % 1073741825);
            3: return 32'($signed(32'($urandom_range(2048))) - 1024);
            default: return 32'($signed(32'($urandom_range(1200000000))) - 600000000);
        endcase
    endfunction

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(5))
            0: return 32'h00010000;
            1: return 32'h0;
            2: return $urandom();
            default: return 32'($signed(32'($urandom_range(1 << 22))) - (1 << 21));
        endcase
    endfunction

    function automatic logic [qform_pkg::IN_W-1:0] pack_header(
        input logic [15:0] code, input logic [31:0] b, input logic [31:0] c,
        input logic [31:0] dq, input logic [31:0] ox, input logic [31:0] oy,
        input logic [31:0] oz, input logic [31:0] vi, input logic [31:0] vj,
        input logic [31:0] vk, input logic qn, input logic [2:0] dims);
        return {4'b0, dims, qn, vk, vj, vi, oz, oy, ox, dq, c, b, code};
    endfunction

    // Valid stays high between back-to-back transactions and drops only while idling.
    task automatic send_header(input logic [qform_pkg::IN_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_random();
        logic [15:0] code;
        code = ($urandom_range(9) == 0) ? 16'($signed(-32'($urandom_range(32768))))
                                         : 16'($urandom_range(32767, 1));
        if ($urandom_range(19) == 0)
            code = 16'($urandom());
        send_header(pack_header(code, rand_quat(), rand_quat(), rand_quat(),
                                rand_q16(), rand_q16(), rand_q16(),
                                rand_q16(), rand_q16(), rand_q16(),
                                1'($urandom_range(1)), 3'($urandom_range(7))));
    endtask

    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int cnt;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: error codes, identity, half-turn, degenerate and over-unit quaternions,
        // voxel sign handling, saturation and every dimension count.
        send_header(pack_header(16'h0, 0, 0, 0, 1, 2, 3, 4, 5, 6, 0, 3));
        send_header(pack_header(16'h8000, '1, '1, '1, '1, '1, '1, '1, '1, '1, 1, 7));
        send_header(pack_header(16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_header(pack_header(16'h7FFF, 0, 0, 0, 0, 0, 0, 32'h10000, 32'h20000,
                                32'h30000, 0, 3));
        send_header(pack_header(16'h1, 32'h40000000, 0, 0, 32'h7FFFFFFF, 32'h80000000, 0,
                                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 3));
        send_header(pack_header(16'h2, 0, 32'hC0000000, 0, 32'h80000000, 32'h7FFFFFFF,
                                32'h80000000, 32'h80000000, 0, 32'hFFFFFFFF, 1, 3));
        send_header(pack_header(16'h1, 0, 0, 32'h40000000, 0, 0, 0, 0, 0, 0, 1, 2));
        send_header(pack_header(16'h1, 32'h40000000, 32'h40000000, 32'h40000000, 5, 6, 7,
                                32'h18000, 32'h8000, 32'h4000, 0, 1));
        send_header(pack_header(16'h1, 32'hC0000000, 32'hC0000000, 32'hC0000000, 0, 0, 0,
                                32'h10000, 32'h10000, 32'h10000, 1, 0));
        send_header(pack_header(16'h3, 32'h2D413CCD, 32'h2D413CCC, 0, 0, 0, 0,
                                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1, 3));
        send_header(pack_header(16'h1, 32'h20000000, 32'h20000000, 32'h20000000,
                                32'h1234, 32'h5678, 32'h9ABC, 32'h10000, 32'h20000,
                                32'h8000, 1, 4));
        for (int k = 0; k < 8; k++)
            send_header(pack_header(16'h1, 32'h10000000, 32'hF0000000, 32'h08000000,
                                    $urandom(), $urandom(), $urandom(), 32'h28000,
                                    32'hFFFF0000, 32'h14000, k[0], k[2:0]));

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 49; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 49; end
                3: begin send_idle_pct = 28; stall_pct = 28; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            for (int k = 0; k < 90; k++)
                send_random();
        end
        s_tvalid <= 1'b0;

        cnt = 0;
        while (pending != 0 && cnt < 200000)
        begin
            @(posedge clk);
            cnt++;
        end
        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

@@ qform_quaternion_to_affine_core.f @@
hdl/qform_pkg.sv
hdl/qform_quaternion_to_affine_core.sv
tb/qform_affine_checker.sv
tb/tb_qform_quaternion_to_affine_core.sv
